// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared sizes, result codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QueueDepth  = 16;
  localparam int KeyW        = 8;
  localparam int IdW         = 16;
  localparam int CountW      = $clog2(QueueDepth + 1);
  localparam int EntryCountW = 5;
  localparam int StatusW     = 2;

  typedef enum logic [StatusW-1:0] {
    StEnqueued = 2'd0,
    StDequeued = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic {
    ReqEnqueue = 1'b0,
    ReqDequeue = 1'b1
  } req_e;

  // Broadcast to every cell in the chain for one request.
  typedef struct packed {
    logic insert;  // place the new entry, shift the tail down
    logic remove;  // shift the whole row up by one
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted-row priority queue built from a chain of compare-and-shift
// cells; equal keys leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request kind
//   (enqueue or dequeue), tdata the identifier and the priority key. Each
//   request gives exactly one result on the m_axis channel: tuser carries
//   the status (enqueued, dequeued, empty, full), tdata the dequeued
//   identifier and key (zero otherwise) and the entry count afterwards.
//   Every cell compares its own key against the incoming key in parallel,
//   so the whole row is updated at once: the cells and the output register
//   are all loaded on the clock edge that accepts the request.
//   Throughput is one request per cycle while the receiver takes each
//   result, set by the parallel row update and one-deep output register.
//   If the receiver stalls, the result is held in the output register and
//   a new request is taken only in a cycle in which that register empties.
//   Reset clears the entry count and the output valid; the cell contents
//   need no clearing, as only cells below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] entry_id, [23:16] priority_key
  input  wire logic        s_axis_tuser,   // [0] req_type
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [15:0] out_id, [23:16] out_key,
                                           // [28:24] entry_count, [31:29] zero
  output      logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int Depth = spq_pkg::QueueDepth;

  // Request decode
  logic                         req_accept;
  logic                         req_is_deq;
  logic [spq_pkg::KeyW-1:0]     new_key;
  logic [spq_pkg::IdW-1:0]      new_id;
  logic                         is_full;
  logic                         is_empty;
  spq_pkg::cell_ctrl_t          ctrl;

  // Count and output register
  logic [spq_pkg::CountW-1:0]   count_q, count_d;
  logic                         out_valid_q;
  spq_pkg::status_e             status_q, status_d;
  logic [spq_pkg::IdW-1:0]      out_id_q, out_id_d;
  logic [spq_pkg::KeyW-1:0]     out_key_q, out_key_d;
  logic [spq_pkg::CountW-1:0]   out_count_q;

  // Cell row wiring
  logic [Depth-1:0]             keep;
  logic [spq_pkg::KeyW-1:0]     cell_key [Depth];
  logic [spq_pkg::IdW-1:0]      cell_id  [Depth];

  assign req_is_deq = (s_axis_tuser == spq_pkg::ReqDequeue);
  assign new_id     = s_axis_tdata[15:0];
  assign new_key    = s_axis_tdata[23:16];

  // Take a new request whenever the result slot is free or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req_accept    = s_axis_tvalid && s_axis_tready;

  assign is_full  = (count_q == spq_pkg::CountW'(Depth));
  assign is_empty = (count_q == '0);

  assign ctrl.insert = req_accept && !req_is_deq && !is_full;
  assign ctrl.remove = req_accept && req_is_deq && !is_empty;

  // Chain of cells, head at index 0.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                     occ;
    logic                     l_keep;
    logic [spq_pkg::KeyW-1:0] l_key, r_key;
    logic [spq_pkg::IdW-1:0]  l_id, r_id;

    assign occ = (spq_pkg::CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_key  = new_key;
      assign l_id   = new_id;
    end else begin : g_body
      assign l_keep = keep[i-1];
      assign l_key  = cell_key[i-1];
      assign l_id   = cell_id[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign r_key = cell_key[i];
      assign r_id  = cell_id[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_id  = cell_id[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occ),
      .new_key_i   (new_key),
      .new_id_i    (new_id),
      .left_keep_i (l_keep),
      .left_key_i  (l_key),
      .left_id_i   (l_id),
      .right_key_i (r_key),
      .right_id_i  (r_id),
      .keep_o      (keep[i]),
      .key_o       (cell_key[i]),
      .id_o        (cell_id[i])
    );
  end

  // Result of the request, formed from the head cell and the count.
  always_comb begin
    count_d   = count_q;
    status_d  = spq_pkg::StEnqueued;
    out_id_d  = '0;
    out_key_d = '0;
    if (!req_is_deq) begin
      if (is_full) begin
        status_d = spq_pkg::StFull;
      end else begin
        count_d = count_q + spq_pkg::CountW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = spq_pkg::StEmpty;
      end else begin
        status_d  = spq_pkg::StDequeued;
        out_id_d  = cell_id[0];
        out_key_d = cell_key[0];
        count_d   = count_q - spq_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled, load on each accepted request.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      status_q    <= status_d;
      out_id_q    <= out_id_d;
      out_key_q   <= out_key_d;
      out_count_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, spq_pkg::EntryCountW'(out_count_q), out_key_q, out_id_q};

`ifndef NO_ASSERTIONS
  // Count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CountW'(Depth))
    else $error("entry count above queue depth");

  // An enqueue into a non-full queue grows the count by one.
  a_enq_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> (count_q == $past(count_q) + spq_pkg::CountW'(1)))
    else $error("enqueue did not grow the count");

  // The two highest held entries stay in descending key order.
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= spq_pkg::CountW'(2)) |-> (cell_key[0] >= cell_key[1]))
    else $error("head of the row out of key order");

  // A dequeued result reports the entry at the head before the request.
  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> (out_key_q == $past(cell_key[0]) && out_id_q == $past(cell_id[0])))
    else $error("dequeue result does not match head entry");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted row: holds a key and an identifier and trades them
// with its neighbours on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                 clk_i,
  input  wire spq_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic                 occupied_i,
  input  wire logic [spq_pkg::KeyW-1:0] new_key_i,
  input  wire logic [spq_pkg::IdW-1:0]  new_id_i,
  input  wire logic                 left_keep_i,
  input  wire logic [spq_pkg::KeyW-1:0] left_key_i,
  input  wire logic [spq_pkg::IdW-1:0]  left_id_i,
  input  wire logic [spq_pkg::KeyW-1:0] right_key_i,
  input  wire logic [spq_pkg::IdW-1:0]  right_id_i,
  output      logic                 keep_o,
  output      logic [spq_pkg::KeyW-1:0] key_o,
  output      logic [spq_pkg::IdW-1:0]  id_o
);

  logic [spq_pkg::KeyW-1:0] key_q, key_d;
  logic [spq_pkg::IdW-1:0]  id_q, id_d;

  // Equal keys stay ahead of the newcomer, which keeps arrival order.
  assign keep_o = occupied_i && (key_q >= new_key_i);

  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          key_d = new_key_i;
          id_d  = new_id_i;
        end else begin
          key_d = left_key_i;
          id_d  = left_id_i;
        end
      end
    end else if (ctrl_i.remove) begin
      key_d = right_key_i;
      id_d  = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign key_o = key_q;
  assign id_o  = id_q;

endmodule

`default_nettype wire

// ----- tb/stable_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives enqueue and dequeue requests into the queue and keeps its own sorted
// copy of the stored entries. Each request accepted on s_axis is served
// against that copy. Each result on m_axis is compared field by field with
// the oldest outstanding expectation. Both channels idle at random, with one
// stretch kept free of gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 14;

  typedef struct packed {
    spq_pkg::status_e                status;
    logic [spq_pkg::IdW-1:0]         id;
    logic [spq_pkg::KeyW-1:0]        key;
    logic [spq_pkg::EntryCountW-1:0] count;
  } queue_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [15:0] entry_id, [23:16] priority_key
  logic        s_axis_tuser  = 1'b0; // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [15:0] out_id, [23:16] out_key, [28:24] entry_count
  logic [1:0]  m_axis_tuser;         // [1:0] status

  // Own copy of the queue contents, head first.
  logic [spq_pkg::KeyW-1:0] held_keys [spq_pkg::QueueDepth];
  logic [spq_pkg::IdW-1:0]  held_ids  [spq_pkg::QueueDepth];
  int                       held_total = 0;

  queue_result_t pending_results[$];
  queue_result_t observed;
  queue_result_t wanted;

  bit gaps_enabled = 1'b1;
  int mismatch_count = 0;
  int cycle_count = 0;

  stable_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("stable_priority_queue verification failed");
      $finish;
    end
  end

  // Serve one request against the local copy and return the result it gives.
  // Insert after every entry with a greater or equal key so ties keep
  // their arrival order; remove from the head.
  function automatic queue_result_t serve_request(spq_pkg::req_e kind,
                                                  logic [spq_pkg::IdW-1:0] id,
                                                  logic [spq_pkg::KeyW-1:0] key);
    queue_result_t res;
    int pos;
    res = '{status: spq_pkg::StEnqueued, id: '0, key: '0, count: '0};
    if (kind == spq_pkg::ReqEnqueue) begin
      if (held_total >= spq_pkg::QueueDepth) begin
        res.status = spq_pkg::StFull;
      end else begin
        pos = 0;
        while (pos < held_total && held_keys[pos] >= key) pos++;
        for (int i = held_total; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_ids[i]  = held_ids[i-1];
        end
        held_keys[pos] = key;
        held_ids[pos]  = id;
        held_total++;
        res.status = spq_pkg::StEnqueued;
      end
    end else if (held_total == 0) begin
      res.status = spq_pkg::StEmpty;
    end else begin
      res.status = spq_pkg::StDequeued;
      res.id     = held_ids[0];
      res.key    = held_keys[0];
      for (int i = 1; i < held_total; i++) begin
        held_keys[i-1] = held_keys[i];
        held_ids[i-1]  = held_ids[i];
      end
      held_total--;
    end
    res.count = spq_pkg::EntryCountW'(held_total);
    return res;
  endfunction

  // Offer one request, hold it until accepted, then record what it must give.
  // Valid stays high straight into the next request unless a gap is drawn.
  task automatic send_request(spq_pkg::req_e kind, logic [spq_pkg::IdW-1:0] id,
                              logic [spq_pkg::KeyW-1:0] key);
    while (gaps_enabled && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {key, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(serve_request(kind, id, key));
  endtask

  // Result side: stall at random and check each result taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed.status = spq_pkg::status_e'(m_axis_tuser);
      observed.id     = m_axis_tdata[15:0];
      observed.key    = m_axis_tdata[23:16];
      observed.count  = m_axis_tdata[28:24];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing outstanding: status %0d id %h key %h count %0d",
                 $time, observed.status, observed.id, observed.key, observed.count);
      end else begin
        wanted = pending_results.pop_front();
        if (observed.status != wanted.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, wanted.status,
                   observed.status);
        end
        if (observed.id != wanted.id) begin
          mismatch_count++;
          $display("%0t: out_id expected %h actual %h", $time, wanted.id, observed.id);
        end
        if (observed.key != wanted.key) begin
          mismatch_count++;
          $display("%0t: out_key expected %h actual %h", $time, wanted.key, observed.key);
        end
        if (observed.count != wanted.count) begin
          mismatch_count++;
          $display("%0t: entry_count expected %0d actual %0d", $time, wanted.count,
                   observed.count);
        end
      end
    end
    m_axis_tready <= !gaps_enabled || ($urandom_range(99) >= IdlePct);
  end

  // Dequeue straight after reset: reported empty, count stays zero.
  task automatic test_empty_dequeue();
    send_request(spq_pkg::ReqDequeue, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::ReqDequeue, 16'h0000, 8'h00);
  endtask

  // Fill to the brim with extreme keys and ids and some ties, then push
  // one more request that must be refused as full.
  task automatic test_fill_and_refuse();
    send_request(spq_pkg::ReqEnqueue, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::ReqEnqueue, 16'h0000, 8'h00);
    send_request(spq_pkg::ReqEnqueue, 16'hAAAA, 8'h80);
    send_request(spq_pkg::ReqEnqueue, 16'h5555, 8'h7F);
    send_request(spq_pkg::ReqEnqueue, 16'h0001, 8'h07);
    send_request(spq_pkg::ReqEnqueue, 16'h0002, 8'h07);
    send_request(spq_pkg::ReqEnqueue, 16'h0003, 8'h07);
    send_request(spq_pkg::ReqEnqueue, 16'h0004, 8'hFF);
    send_request(spq_pkg::ReqEnqueue, 16'h0005, 8'h00);
    for (int i = 0; i < spq_pkg::QueueDepth - 9; i++)
      send_request(spq_pkg::ReqEnqueue, spq_pkg::IdW'($urandom), spq_pkg::KeyW'($urandom));
    send_request(spq_pkg::ReqEnqueue, 16'hFFFF, 8'hFF);
  endtask

  // Take a few from the head: the two top keys must leave in arrival order.
  task automatic test_stable_drain();
    for (int i = 0; i < 4; i++)
      send_request(spq_pkg::ReqDequeue, spq_pkg::IdW'($urandom), spq_pkg::KeyW'($urandom));
  endtask

  // Rounds of random traffic, alternately biased towards filling and
  // draining so both full and empty are hit often. Narrow keys force ties.
  task automatic test_random_traffic();
    int enq_pct;
    spq_pkg::req_e kind;
    logic [spq_pkg::KeyW-1:0] key;
    for (int round = 0; round < 10; round++) begin
      enq_pct      = (round % 2 == 0) ? 75 : 25;
      gaps_enabled = (round != 4);
      for (int n = 0; n < 40; n++) begin
        kind = ($urandom_range(99) < enq_pct) ? spq_pkg::ReqEnqueue : spq_pkg::ReqDequeue;
        key  = ($urandom_range(1) == 0) ? spq_pkg::KeyW'($urandom_range(3))
                                        : spq_pkg::KeyW'($urandom);
        send_request(kind, spq_pkg::IdW'($urandom), key);
      end
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_fill_and_refuse();
    test_stable_drain();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("stable_priority_queue verification clean");
    end else begin
      $display("stable_priority_queue verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
